// ===== src/fvs_pkg.sv =====
// Package for the frame victim selector: field widths, command codes,
// sequencer states and the control struct to the compare unit.
// No dependencies; every other file imports it.
package fvs_pkg;

  localparam int FRAME_COUNT_DEF = 128;
  localparam int FRAME_W         = 7;
  localparam int TICK_W          = 32;
  localparam int CMD_W           = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_VICTIM = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control for one step of the shared compare unit.
  typedef struct packed {
    logic clear;
    logic sample;
    logic lru;
  } cmp_ctrl_t;

endpackage

// ===== src/fvs_if.sv =====
// Valid/ready channel interfaces for the frame victim selector.
// Depends on fvs_pkg for the field widths.
interface fvs_req_if import fvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [FRAME_W-1:0] frame_number;
  logic              swappable_flag;
  logic [TICK_W-1:0] tick_value;

  modport source (output valid, command, frame_number, swappable_flag, tick_value,
                  input ready);
  modport sink   (input valid, command, frame_number, swappable_flag, tick_value,
                  output ready);
endinterface

interface fvs_rsp_if import fvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] victim_frame;
  logic               victim_found;

  modport source (output valid, victim_frame, victim_found, input ready);
  modport sink   (input valid, victim_frame, victim_found, output ready);
endinterface

// ===== src/fvs_time_store.sv =====
// Last-use timestamp memory: one write port, one registered read port.
// Per-entry valid flops make unwritten entries read as zero. Uses fvs_pkg.
module fvs_time_store import fvs_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int FIDX_W      = $clog2(FRAME_COUNT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [FIDX_W-1:0] wr_addr,
  input  logic [TICK_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [FIDX_W-1:0] rd_addr,
  output logic [TICK_W-1:0] rd_data
);

  logic [TICK_W-1:0]      mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] written;
  logic [TICK_W-1:0]      mem_q;
  logic                   written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      written_q <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = written_q ? mem_q : '0;

endmodule

// ===== src/fvs_compare_unit.sv =====
// Shared compare unit: folds one candidate frame per step into the best pick.
// Round-robin keeps the first swappable candidate, LRU the oldest. Uses fvs_pkg.
module fvs_compare_unit import fvs_pkg::*; #(
  parameter int FIDX_W = $clog2(FRAME_COUNT_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  cmp_ctrl_t         ctrl,
  input  logic [FIDX_W-1:0] cand_idx,
  input  logic              cand_swap,
  input  logic [TICK_W-1:0] cand_time,
  output logic [FIDX_W-1:0] best_idx,
  output logic              best_found
);

  logic [FIDX_W-1:0] best;
  logic [TICK_W-1:0] best_time;
  logic              found;
  logic              take;

  // Strict less-than keeps the earlier index on equal timestamps.
  assign take = cand_swap && (!found || (ctrl.lru && (cand_time < best_time)));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      best  <= '0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
      best  <= '0;
    end else if (ctrl.sample && take) begin
      found <= 1'b1;
      best  <= cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample && take) begin
      best_time <= cand_time;
    end
  end

  assign best_idx   = best;
  assign best_found = found;

endmodule

// ===== src/frame_victim_selector.sv =====
// Top level of the frame victim selector: sequencer, swappable bits,
// round-robin pointer and result register. Uses fvs_pkg, fvs_if,
// fvs_time_store and fvs_compare_unit.
//
//  channel   dir  handshake              beat contents
//  req       in   req.valid/req.ready    command, frame_number, swappable_flag, tick_value
//  rsp       out  rsp.valid/rsp.ready    victim_frame, victim_found
//  cfg       in   cfg_wr_en              cfg_wr_data -> policy
//
// Set, record and unused command beats give no result.
// A victim request goes from its accept cycle into a scan of one frame per cycle
// through the timestamp memory read port and the compare unit, then a drain step
// for the read pipeline and a finish step that loads the result.
// Reset clears the swappable bits, the timestamp valid flops, the pointer and
// the policy; the block is ready the cycle after reset drops.
// The input is not ready while a request is scanning. A finished result waits
// in the output register; a further request scans meanwhile and holds in its
// last step until that register frees up.
module frame_victim_selector import fvs_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fvs_req_if.sink    req,
  fvs_rsp_if.source  rsp,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  localparam int FIDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W  = FIDX_W + 1;
  localparam int WIDE_W = (FIDX_W > FRAME_W) ? FIDX_W : FRAME_W;

  state_t state, state_next;

  logic                   policy;
  logic [FRAME_COUNT-1:0] swap_bits;
  logic [FIDX_W-1:0]      ptr;
  logic [FIDX_W-1:0]      base;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cand_sum;
  logic [FIDX_W-1:0]      cand;
  logic                   last_issue;

  // Read pipeline stage: index and swappable bit line up with memory data.
  logic                   s1_valid;
  logic [FIDX_W-1:0]      s1_idx;
  logic                   s1_swap;
  logic [TICK_W-1:0]      rd_time;

  logic                   out_valid;
  logic [FRAME_W-1:0]     out_frame;
  logic                   out_found;
  logic                   out_free;

  logic [WIDE_W:0]        frame_wide;
  logic                   frame_ok;
  logic [FIDX_W-1:0]      frame_idx;
  logic                   accept;
  logic                   wr_time;

  cmp_ctrl_t              cmp_ctrl;
  logic [FIDX_W-1:0]      best_idx;
  logic                   best_found;
  logic [WIDE_W-1:0]      best_wide;
  logic                   rd_en;
  logic                   finish;

  // Decode the frame number; drop set and record beats beyond the last frame.
  assign frame_wide = (WIDE_W + 1)'(req.frame_number);
  assign frame_ok   = frame_wide < (WIDE_W + 1)'(FRAME_COUNT);
  assign frame_idx  = frame_wide[FIDX_W-1:0];
  assign accept     = req.valid && req.ready;
  assign wr_time    = accept && (command_t'(req.command) == CMD_RECORD) && frame_ok;

  // Candidate frame: start point plus step count, wrapped once.
  assign cand_sum   = CNT_W'(base) + cnt;
  assign cand       = (cand_sum >= CNT_W'(FRAME_COUNT)) ?
                      FIDX_W'(cand_sum - CNT_W'(FRAME_COUNT)) : FIDX_W'(cand_sum);
  assign last_issue = cnt == CNT_W'(FRAME_COUNT - 1);

  assign out_free   = !out_valid || rsp.ready;
  assign best_wide  = WIDE_W'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    req.ready       = 1'b0;
    rd_en           = 1'b0;
    finish          = 1'b0;
    cmp_ctrl.clear  = 1'b0;
    cmp_ctrl.sample = s1_valid;
    cmp_ctrl.lru    = policy;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && (command_t'(req.command) == CMD_VICTIM)) begin
          cmp_ctrl.clear = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the result register can take the beat.
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= 1'b0;
      swap_bits <= '0;
      ptr       <= '0;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy <= cfg_wr_data;
      end
      if (accept && (command_t'(req.command) == CMD_SET) && frame_ok) begin
        swap_bits[frame_idx] <= req.swappable_flag;
      end
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
      s1_valid <= rd_en;
      // Advance the pointer past a round-robin pick; leave it when none found.
      if (finish && !policy && best_found) begin
        ptr <= (best_idx == FIDX_W'(FRAME_COUNT - 1)) ? '0 : best_idx + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && (command_t'(req.command) == CMD_VICTIM)) begin
      base <= policy ? '0 : ptr;
    end
    if (rd_en) begin
      s1_idx  <= cand;
      s1_swap <= swap_bits[cand];
    end
    if (finish) begin
      out_frame <= best_wide[FRAME_W-1:0];
      out_found <= best_found;
    end
  end

  fvs_time_store #(
    .FRAME_COUNT (FRAME_COUNT),
    .FIDX_W      (FIDX_W)
  ) u_time_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_time),
    .wr_addr (frame_idx),
    .wr_data (req.tick_value),
    .rd_en   (rd_en),
    .rd_addr (cand),
    .rd_data (rd_time)
  );

  fvs_compare_unit #(
    .FIDX_W (FIDX_W)
  ) u_compare_unit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (cmp_ctrl),
    .cand_idx   (s1_idx),
    .cand_swap  (s1_swap),
    .cand_time  (rd_time),
    .best_idx   (best_idx),
    .best_found (best_found)
  );

  assign rsp.valid        = out_valid;
  assign rsp.victim_frame = out_frame;
  assign rsp.victim_found = out_found;

endmodule

// ===== sim/tb_frame_victim_selector.sv =====
`timescale 1ns / 100ps
// Self-checking bench for frame_victim_selector.
// It opens with a short directed sequence, then runs random set, record and victim
// beats under both replacement policies and several handshake pressure settings.
// Depends on fvs_pkg, fvs_if and the RTL under src.
module tb_frame_victim_selector;
  import fvs_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int FRAME_COUNT      = FRAME_COUNT_DEF;
  // Long enough for a full victim scan; pad a little on top of that.
  localparam int SETTLE_CYCLES    = FRAME_COUNT + 12;
  localparam int DRAIN_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int PHASE_COUNT      = 8;
  localparam int REPORT_LIMIT     = 10;
  localparam int TIMEOUT_NS       = 20_000_000;

  // Command code 3 has no meaning in the block; it must be swallowed silently.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam logic MODE_ROTATE = 1'b0;
  localparam logic MODE_OLDEST = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame;
    logic               flag;
    logic [TICK_W-1:0]  tick;
  } frame_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               found;
  } victim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic cfg_wr_data;

  fvs_req_if req_bus ();
  fvs_rsp_if rsp_bus ();

  frame_victim_selector #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the block state, updated on every accepted request beat.
  logic                 swap_bits [FRAME_COUNT];
  logic [TICK_W-1:0]    use_stamp [FRAME_COUNT];
  logic [FRAME_W-1:0]   rr_ptr;
  logic                 lru_mode;

  // Beats waiting to be driven, and victims predicted but not yet seen.
  frame_req_t pending_reqs [$];
  victim_t    expected_victims [$];

  // Handshake pressure: percent of cycles the sender idles / receiver stalls.
  int send_idle_pct   = 0;
  int ready_stall_pct = 0;

  logic       req_taken = 1'b0;
  frame_req_t taken;
  victim_t    predicted;
  victim_t    got;
  logic [TICK_W-1:0] best_stamp;
  int         scan_idx;
  int         cand;

  int beats_taken     = 0;
  int victims_checked = 0;
  int victims_found   = 0;
  int mismatches      = 0;

  // Monitor and predictor share one clocked block: check the result side first
  // (it is always older than any request accepted on the same edge), then
  // fold the accepted request into the shadow state.
  always @(posedge clk) begin : victim_tracker
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = {rsp_bus.victim_frame, rsp_bus.victim_found};
      if (expected_victims.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result beat with nothing pending: frame %0d found %0b",
                   $time, got.frame, got.found);
        mismatches++;
      end else begin
        predicted = expected_victims.pop_front();
        victims_checked++;
        if (predicted.found)
          victims_found++;
        if (got.frame !== predicted.frame || got.found !== predicted.found) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: victim mismatch: expected frame %0d found %0b, got frame %0d found %0b",
                     $time, predicted.frame, predicted.found, got.frame, got.found);
          mismatches++;
        end
      end
    end

    // Record the handshake for the driver, which moves on at the next falling edge.
    req_taken = !rst && req_bus.valid && req_bus.ready;
    if (req_taken) begin
      taken = {req_bus.command, req_bus.frame_number, req_bus.swappable_flag,
               req_bus.tick_value};
      beats_taken++;
      case (taken.cmd)
        CMD_SET: begin
          swap_bits[taken.frame] = taken.flag;
        end
        // Timestamps are kept whatever the policy is.
        CMD_RECORD: begin
          use_stamp[taken.frame] = taken.tick;
        end
        CMD_VICTIM: begin
          predicted  = '0;
          best_stamp = '0;
          if (lru_mode == MODE_ROTATE) begin
            // Scan upward from the pointer with wrap; advance the pointer
            // past the hit. An empty scan leaves the pointer alone.
            for (scan_idx = 0; scan_idx < FRAME_COUNT; scan_idx++) begin
              cand = (int'(rr_ptr) + scan_idx) % FRAME_COUNT;
              if (!predicted.found && swap_bits[cand]) begin
                predicted.frame = cand[FRAME_W-1:0];
                predicted.found = 1'b1;
                rr_ptr = FRAME_W'((cand + 1) % FRAME_COUNT);
              end
            end
          end else begin
            // Oldest stamp wins; strict compare keeps the lowest index on ties.
            for (scan_idx = 0; scan_idx < FRAME_COUNT; scan_idx++) begin
              if (swap_bits[scan_idx] && (!predicted.found || use_stamp[scan_idx] < best_stamp)) begin
                best_stamp      = use_stamp[scan_idx];
                predicted.frame = scan_idx[FRAME_W-1:0];
                predicted.found = 1'b1;
              end
            end
          end
          expected_victims.push_back(predicted);
        end
        default: begin
          // Drop the unused command code: no state change, no result.
        end
      endcase
    end
  end

  // Driver and receiver: change inputs at the falling edge only. Hold a beat
  // until it is taken; decide on idling only between beats.
  always @(negedge clk) begin : beat_driver
    if (!(req_bus.valid && !req_taken)) begin
      if (req_bus.valid)
        void'(pending_reqs.pop_front());
      if (!rst && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_bus.valid          <= 1'b1;
        req_bus.command        <= pending_reqs[0].cmd;
        req_bus.frame_number   <= pending_reqs[0].frame;
        req_bus.swappable_flag <= pending_reqs[0].flag;
        req_bus.tick_value     <= pending_reqs[0].tick;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
    rsp_bus.ready <= !rst && ($urandom_range(99) >= ready_stall_pct);
  end

  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] frame,
                               input logic flag, input logic [TICK_W-1:0] tick);
    pending_reqs.push_back({cmd, frame, flag, tick});
  endtask

  // Wait until every queued beat is taken and every victim has come back,
  // then let a full scan's worth of cycles pass so the block is truly idle.
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || req_bus.valid || expected_victims.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    lru_mode = mode;
  endtask

  initial begin : run_sequence
    int ph;
    int n;
    int set_bias;
    int roll;
    logic [CMD_W-1:0]   cmd_sel;
    logic [FRAME_W-1:0] frame_sel;
    logic [TICK_W-1:0]  tick_sel;

    cfg_wr_en              = 1'b0;
    cfg_wr_data            = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.command        = CMD_SET;
    req_bus.frame_number   = '0;
    req_bus.swappable_flag = 1'b0;
    req_bus.tick_value     = '0;
    rsp_bus.ready          = 1'b0;

    // Shadow state matches the block after reset: nothing swappable.
    for (n = 0; n < FRAME_COUNT; n++) begin
      swap_bits[n] = 1'b0;
      use_stamp[n] = '0;
    end
    rr_ptr   = '0;
    lru_mode = MODE_ROTATE;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening, round-robin policy from reset.
    queue_request(CMD_VICTIM, 0, 1'b0, '0);            // nothing swappable: frame 0, not found
    queue_request(CMD_SET, 127, 1'b1, '0);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);            // top frame; pointer wraps to 0
    queue_request(CMD_SET, 0, 1'b1, '0);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);            // scan from 1 up to the top frame
    queue_request(CMD_RECORD, 5, 1'b0, 32'hFFFF_FFFF); // stamp stored under round-robin too
    queue_request(CMD_SET, 5, 1'b1, '0);
    queue_request(CMD_SET, 127, 1'b0, '0);             // pin the top frame again
    queue_request(CMD_RESERVED, 0, 1'b0, 32'hFFFF_FFFF);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);
    settle();

    // Directed LRU part: ties, oldest stamp, pinned frames, empty set.
    write_policy(MODE_OLDEST);
    queue_request(CMD_RECORD, 0, 1'b1, 32'hFFFF_FFFF); // tie with frame 5
    queue_request(CMD_VICTIM, 0, 1'b0, '0);            // lowest index wins the tie
    queue_request(CMD_RECORD, 5, 1'b0, '0);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);
    queue_request(CMD_RECORD, 127, 1'b0, '0);          // pinned frame with the oldest stamp
    queue_request(CMD_VICTIM, 0, 1'b0, '0);
    queue_request(CMD_SET, 0, 1'b0, '0);
    queue_request(CMD_SET, 5, 1'b0, '0);
    queue_request(CMD_VICTIM, 0, 1'b0, '0);            // empty again under LRU
    settle();

    // Random phases: alternate the policy, step through the pressure settings
    // so each one runs under both policies.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      write_policy((ph % 2) ? MODE_OLDEST : MODE_ROTATE);
      case (ph / 2)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 76; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 76; end
        default: begin send_idle_pct = 33; ready_stall_pct = 33; end
      endcase
      set_bias = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 50 : 85;

      // Twice, clear every frame and open only a few, so scans run long,
      // wrap around and come up empty once those few are pinned again.
      if (ph == 3 || ph == 4) begin
        for (n = 0; n < FRAME_COUNT; n++)
          queue_request(CMD_SET, n[FRAME_W-1:0], 1'b0, $urandom());
        for (n = 0; n < 3; n++)
          queue_request(CMD_SET, FRAME_W'($urandom_range(FRAME_COUNT - 1)), 1'b1,
                        $urandom());
      end

      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 38)
          cmd_sel = CMD_SET;
        else if (roll < 63)
          cmd_sel = CMD_RECORD;
        else if (roll < 95)
          cmd_sel = CMD_VICTIM;
        else
          cmd_sel = CMD_RESERVED;

        // Favor both ends of the frame range so wrap and low-index ties show up.
        case ($urandom_range(3))
          0:       frame_sel = FRAME_W'($urandom_range(7));
          1:       frame_sel = FRAME_W'(FRAME_COUNT - 1 - $urandom_range(7));
          default: frame_sel = FRAME_W'($urandom_range(FRAME_COUNT - 1));
        endcase

        // Small stamps give frequent LRU ties; also hit both extremes.
        case ($urandom_range(9))
          0:       tick_sel = '0;
          1:       tick_sel = '1;
          2, 3, 4: tick_sel = $urandom_range(3);
          default: tick_sel = $urandom();
        endcase

        queue_request(cmd_sel, frame_sel, ($urandom_range(99) < set_bias), tick_sel);
      end
      settle();
    end

    $display("ran %0d request beats over both policies and four pressure settings",
             beats_taken);
    $display("checked %0d victims (%0d found, %0d empty), %0d mismatches, %0d left pending",
             victims_checked, victims_found, victims_checked - victims_found, mismatches,
             expected_victims.size());
    if (mismatches == 0 && expected_victims.size() == 0 && pending_reqs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
